>>> hw/rtl/lir_pkg.sv
// ---------------------------------------------------------------------------
// lir_pkg - shared types and constants of the linear interpolation resampler
// configuration register indexes and the side-band carried through the pipe
// ---------------------------------------------------------------------------
package lir_pkg;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_RATIO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_STEREO  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_STEREO = 2'd2;

    // channel mode as set by the configuration registers
    typedef struct packed {
        logic in_stereo;
        logic out_stereo;
    } lir_mode_t;

    // tag that travels beside the lane data
    typedef struct packed {
        logic valid;
        logic last;
    } lir_tag_t;

endpackage

>>> hw/rtl/lir_lane.sv
// ---------------------------------------------------------------------------
// lir_lane - one channel of the interpolator
// forms the exact numerator a*2^FRAC_BITS + (b - a)*alpha over two stages
// ---------------------------------------------------------------------------
module lir_lane #(
    parameter int SAMPLE_BITS = 24,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                     clk,
    input  logic                                     en,
    input  logic signed [SAMPLE_BITS-1:0]            a,
    input  logic signed [SAMPLE_BITS-1:0]            b,
    input  logic        [FRAC_BITS-1:0]              alpha,
    output logic signed [SAMPLE_BITS+FRAC_BITS+1:0]  num
);

    localparam int NW = SAMPLE_BITS + FRAC_BITS + 2;

    logic signed [SAMPLE_BITS:0]   diff;
    logic signed [FRAC_BITS:0]     alpha_s;
    logic signed [NW-1:0]          prod_next;
    logic signed [NW-1:0]          prod_reg;
    logic signed [SAMPLE_BITS-1:0] base_reg;
    logic signed [NW-1:0]          base_ext;
    logic signed [NW-1:0]          num_reg;

    assign diff      = {b[SAMPLE_BITS-1], b} - {a[SAMPLE_BITS-1], a};
    assign alpha_s   = $signed({1'b0, alpha});
    assign prod_next = diff * alpha_s;
    assign base_ext  = {{(NW-SAMPLE_BITS){base_reg[SAMPLE_BITS-1]}}, base_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            base_reg <= a;
            num_reg  <= (base_ext <<< FRAC_BITS) + prod_reg;
        end
    end

    assign num = num_reg;

endmodule

>>> hw/rtl/lir_merge.sv
// ---------------------------------------------------------------------------
// lir_merge - combines the two lanes into one output item
// truncates toward zero, forms the mono average and holds the output register
// ---------------------------------------------------------------------------
module lir_merge #(
    parameter int SAMPLE_BITS = 24,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  lir_pkg::lir_mode_t                       mode,
    input  lir_pkg::lir_tag_t                        tag,
    input  logic signed [SAMPLE_BITS+FRAC_BITS+1:0]  num_l,
    input  logic signed [SAMPLE_BITS+FRAC_BITS+1:0]  num_r,
    input  logic                                     out_ready,
    output logic                                     out_valid,
    output logic                                     out_last,
    output logic        [SAMPLE_BITS-1:0]            out_left,
    output logic        [SAMPLE_BITS-1:0]            out_right,
    output logic                                     en
);

    localparam int NW = SAMPLE_BITS + FRAC_BITS + 2;
    localparam logic signed [NW-1:0] BIAS_ONE = NW'((64'd1 << FRAC_BITS) - 64'd1);
    localparam logic signed [NW:0]   BIAS_TWO = (NW+1)'((64'd1 << (FRAC_BITS + 1)) - 64'd1);

    logic signed [NW-1:0]          tl;
    logic signed [NW-1:0]          tr;
    logic signed [NW:0]            sum;
    logic signed [NW:0]            ts;
    logic        [SAMPLE_BITS-1:0] ql;
    logic        [SAMPLE_BITS-1:0] qr;
    logic        [SAMPLE_BITS-1:0] qs;
    logic        [SAMPLE_BITS-1:0] left_next;
    logic        [SAMPLE_BITS-1:0] right_next;
    logic                          valid_reg;
    logic                          last_reg;
    logic        [SAMPLE_BITS-1:0] left_reg;
    logic        [SAMPLE_BITS-1:0] right_reg;

    always_comb
    begin
        // bias negative values so the arithmetic shift rounds toward zero
        tl  = num_l + (num_l[NW-1] ? BIAS_ONE : '0);
        tr  = num_r + (num_r[NW-1] ? BIAS_ONE : '0);
        sum = {num_l[NW-1], num_l} + {num_r[NW-1], num_r};
        ts  = sum + (sum[NW] ? BIAS_TWO : '0);
        ql  = SAMPLE_BITS'(tl >>> FRAC_BITS);
        qr  = SAMPLE_BITS'(tr >>> FRAC_BITS);
        qs  = SAMPLE_BITS'(ts >>> (FRAC_BITS + 1));
        if (!mode.out_stereo && mode.in_stereo)
        begin
            left_next  = qs;
            right_next = qs;
        end
        else
        begin
            left_next  = ql;
            right_next = mode.in_stereo ? qr : ql;
        end
    end

    assign en = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= tag.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            last_reg  <= tag.last;
            left_reg  <= left_next;
            right_reg <= right_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_last  = last_reg;
    assign out_left  = left_reg;
    assign out_right = right_reg;

endmodule

>>> hw/rtl/linear_interp_resampler.sv
// ---------------------------------------------------------------------------
// linear_interp_resampler - linear interpolation sample rate converter
// resamples stereo or mono audio frames by a Q16 phase step
// ---------------------------------------------------------------------------
// usage:
// - input frames arrive on the s_ stream (tdata: left, right; tuser: restart)
// - output items leave on the m_ stream (tdata: left, right; tlast marks the
//   final item caused by one input frame)
// - step ratio and channel mode are written on the cfg_ port while idle
// - a first frame or a restart frame is stored and gives no item
// - any other frame occupies the sequencer for its n items, n being the number
//   of items it causes (0 to MAX_RUN), and for one phase wrap step; the sequencer
//   issues one phase a cycle unless the receiver stalls it
// - the first item of a frame passes, once the frame's sequencing starts,
//   through two lane stages and the output register
// - a stalled receiver holds the output register, the lane pipeline and the
//   sequencer together; no item is lost
// - reset clears history and phase and restores the default configuration
//   (unity step, stereo in, stereo out)
// ---------------------------------------------------------------------------
module linear_interp_resampler #(
    parameter int SAMPLE_BITS = 24,
    parameter int FRAC_BITS   = 16,
    parameter int MAX_RUN     = 8
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // s_tdata: left_in, right_in, zero fill
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,
    // s_tuser: restart
    input  logic [0:0]                              s_tuser,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // m_tdata: left_out, right_out, zero fill
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]      m_tdata,
    output logic                                    m_tlast,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    input  logic                                    cfg_we,
    input  logic [lir_pkg::CFG_IDX_W-1:0]           cfg_addr,
    input  logic [FRAC_BITS+3:0]                    cfg_wdata
);

    localparam int DW = ((2*SAMPLE_BITS+7)/8)*8;
    localparam int NW = SAMPLE_BITS + FRAC_BITS + 2;
    localparam int PW = FRAC_BITS + 4;
    localparam int CW = $clog2(MAX_RUN + 1);
    localparam logic [PW-1:0] ONE_PHASE = PW'(1) << FRAC_BITS;
    localparam logic [CW-1:0] RUN_LIMIT = CW'(MAX_RUN);

    logic [PW-1:0]                 step_reg;
    lir_pkg::lir_mode_t            mode_reg;
    logic signed [SAMPLE_BITS-1:0] prev_l_reg;
    logic signed [SAMPLE_BITS-1:0] prev_r_reg;
    logic signed [SAMPLE_BITS-1:0] cur_l_reg;
    logic signed [SAMPLE_BITS-1:0] cur_r_reg;
    logic                          have_prev_reg;
    logic [PW-1:0]                 phase_reg;
    logic [CW-1:0]                 count_reg;
    logic                          busy_reg;
    lir_pkg::lir_tag_t             tag1_reg;
    lir_pkg::lir_tag_t             tag2_reg;
    lir_pkg::lir_tag_t             tag1_next;

    logic                          en;
    logic                          in_acc;
    logic                          restart;
    logic signed [SAMPLE_BITS-1:0] in_left;
    logic signed [SAMPLE_BITS-1:0] in_right;
    logic                          phase_lt_one;
    logic                          can_issue;
    logic                          issue;
    logic                          finish;
    logic [PW:0]                   phase_sum;
    logic [PW-1:0]                 phase_next;
    logic signed [SAMPLE_BITS-1:0] lane_r_a;
    logic signed [SAMPLE_BITS-1:0] lane_r_b;
    logic signed [NW-1:0]          num_l;
    logic signed [NW-1:0]          num_r;
    logic [SAMPLE_BITS-1:0]        out_left;
    logic [SAMPLE_BITS-1:0]        out_right;

    assign in_left  = $signed(s_tdata[SAMPLE_BITS-1:0]);
    assign in_right = $signed(s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
    assign restart  = s_tuser[0];
    assign s_tready = !busy_reg;
    assign in_acc   = s_tvalid && s_tready;

    assign phase_lt_one = (phase_reg[PW-1:FRAC_BITS] == '0);
    assign can_issue    = phase_lt_one && (count_reg != RUN_LIMIT);
    assign issue        = busy_reg && en && can_issue;
    assign finish       = busy_reg && en && !can_issue;

    // saturating phase advance
    assign phase_sum  = {1'b0, phase_reg} + {1'b0, step_reg};
    assign phase_next = phase_sum[PW] ? '1 : phase_sum[PW-1:0];

    always_comb
    begin
        tag1_next.valid = issue;
        tag1_next.last  = (phase_next[PW-1:FRAC_BITS] != '0)
                          || (count_reg == CW'(MAX_RUN - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg            <= ONE_PHASE;
            mode_reg.in_stereo  <= 1'b1;
            mode_reg.out_stereo <= 1'b1;
            prev_l_reg          <= '0;
            prev_r_reg          <= '0;
            have_prev_reg       <= 1'b0;
            phase_reg           <= '0;
            count_reg           <= '0;
            busy_reg            <= 1'b0;
            tag1_reg            <= '0;
            tag2_reg            <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    lir_pkg::CFG_STEP_RATIO: step_reg            <= cfg_wdata;
                    lir_pkg::CFG_IN_STEREO:  mode_reg.in_stereo  <= cfg_wdata[0];
                    lir_pkg::CFG_OUT_STEREO: mode_reg.out_stereo <= cfg_wdata[0];
                    default: ;
                endcase
            end

            if (in_acc)
            begin
                if (restart || !have_prev_reg)
                begin
                    prev_l_reg    <= in_left;
                    prev_r_reg    <= in_right;
                    have_prev_reg <= 1'b1;
                    phase_reg     <= '0;
                end
                else
                begin
                    busy_reg  <= 1'b1;
                    count_reg <= '0;
                end
            end

            if (issue)
            begin
                phase_reg <= phase_next;
                count_reg <= count_reg + CW'(1);
            end

            if (finish)
            begin
                phase_reg  <= phase_lt_one ? '0 : phase_reg - ONE_PHASE;
                prev_l_reg <= cur_l_reg;
                prev_r_reg <= cur_r_reg;
                busy_reg   <= 1'b0;
            end

            if (en)
            begin
                tag1_reg <= tag1_next;
                tag2_reg <= tag1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            cur_l_reg <= in_left;
            cur_r_reg <= in_right;
        end
    end

    // mono input feeds the left channel to both lanes
    assign lane_r_a = mode_reg.in_stereo ? prev_r_reg : prev_l_reg;
    assign lane_r_b = mode_reg.in_stereo ? cur_r_reg  : cur_l_reg;

    lir_lane #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_lane_l (
        .clk   (clk),
        .en    (en),
        .a     (prev_l_reg),
        .b     (cur_l_reg),
        .alpha (phase_reg[FRAC_BITS-1:0]),
        .num   (num_l)
    );

    lir_lane #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_lane_r (
        .clk   (clk),
        .en    (en),
        .a     (lane_r_a),
        .b     (lane_r_b),
        .alpha (phase_reg[FRAC_BITS-1:0]),
        .num   (num_r)
    );

    lir_merge #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode      (mode_reg),
        .tag       (tag2_reg),
        .num_l     (num_l),
        .num_r     (num_r),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_last  (m_tlast),
        .out_left  (out_left),
        .out_right (out_right),
        .en        (en)
    );

    assign m_tdata = DW'({out_right, out_left});

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (count_reg <= RUN_LIMIT))
        else $error("run count beyond limit");

    a_start_run: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && !restart && have_prev_reg) |=> busy_reg)
        else $error("frame with history did not start a run");

    a_run_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && en && (count_reg == RUN_LIMIT)) |=> !busy_reg)
        else $error("run did not end at the limit");

    a_issue_phase: assert property (@(posedge clk) disable iff (!rst_n)
        issue |-> (phase_reg < ONE_PHASE))
        else $error("item issued with phase at or above one");
`endif

endmodule
